/* rtl/modular_exponentiation_macros.svh */
// Assertion macros for the modular exponentiation block.
// Included by modular_exponentiation.sv; empty when SYNTHESIS is defined.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef SYNTHESIS
`define MEXP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mexp: check failed");
`define MEXP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("mexp: forbidden condition");
`else
`define MEXP_ASSERT(lbl, clk, rst_n, prop)
`define MEXP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

/* rtl/mexp_pkg.sv */
// Package for the modular exponentiation block: sequencer states,
// register indexes and reset values. No dependencies.
package mexp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MULT,
    ST_SQUARE,
    ST_DONE
  } mexp_state_e;

  localparam int unsigned CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_EXPONENT = 1'b1;

  localparam logic [63:0] RST_MODULUS  = 64'd60491;
  localparam logic [63:0] RST_EXPONENT = 64'd7;

endpackage

/* rtl/modular_exponentiation.sv */
// Modular exponentiation, right-to-left square-and-multiply, one base per transfer.
// Depends on mexp_pkg and modular_exponentiation_macros.svh.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      tdata: base
//   m_axis    out  m_axis_tvalid/tready      tdata: power_mod
//   cfg       in   cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One shared shift-add modular multiplier step, used to reduce, multiply and square.
// Per base: one reduction, then a multiply at each set exponent bit and a square
// up to the top set bit.
// Reset loads modulus 60491 and exponent 7; s_axis_tready is high only while idle.
// A finished result waits in the output register while the next base is taken.
module modular_exponentiation #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((WORD_BITS+7)/8)*8-1:0]       s_axis_tdata,   // base
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [((WORD_BITS+7)/8)*8-1:0]       m_axis_tdata,   // power_mod
  input  logic                                 cfg_we_i,
  input  logic [mexp_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [WORD_BITS-1:0]                 cfg_wdata_i
);
  import mexp_pkg::*;

  localparam int unsigned TDATA_BITS = ((WORD_BITS + 7) / 8) * 8;
  localparam int unsigned CNT_BITS   = $clog2(WORD_BITS);

  mexp_state_e state_q, state_d;

  logic [WORD_BITS-1:0] m_q, e_q;
  logic [WORD_BITS-1:0] esh_q, esh_d;
  logic [WORD_BITS-1:0] sq_q, sq_d;
  logic [WORD_BITS-1:0] acc_q, acc_d;
  logic [WORD_BITS-1:0] p_q, p_d;
  logic [WORD_BITS-1:0] b_q, b_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [WORD_BITS-1:0] out_q, out_d;
  logic                 ovld_q, ovld_d;

  logic [WORD_BITS-1:0] a_op, step_res, nxt_e;
  logic [WORD_BITS+1:0] sum_x;
  logic [WORD_BITS+2:0] sub1, sub2;
  logic                 last;
  logic                 mul_phase, step_phase;

  // shared unit: p <- (2p + bit*a) mod m
  always_comb begin
    a_op  = (state_q == ST_REDUCE) ? WORD_BITS'(1) : sq_q;
    sum_x = {1'b0, p_q, 1'b0} + {2'b00, (a_op & {WORD_BITS{b_q[WORD_BITS-1]}})};
    sub1  = {1'b0, sum_x} - {3'b000, m_q};
    sub2  = {1'b0, sum_x} - {2'b00, m_q, 1'b0};
    if (!sub2[WORD_BITS+2]) begin
      step_res = sub2[WORD_BITS-1:0];
    end else if (!sub1[WORD_BITS+2]) begin
      step_res = sub1[WORD_BITS-1:0];
    end else begin
      step_res = sum_x[WORD_BITS-1:0];
    end
  end

  assign last  = (cnt_q == CNT_BITS'(WORD_BITS - 1));
  assign nxt_e = (state_q == ST_SQUARE) ? (esh_q >> 1) : esh_q;

  assign mul_phase  = (state_q == ST_MULT) || (state_q == ST_SQUARE);
  assign step_phase = mul_phase || (state_q == ST_REDUCE);

  always_comb begin
    state_d = state_q;
    esh_d   = esh_q;
    sq_d    = sq_q;
    acc_d   = acc_q;
    p_d     = p_q;
    b_d     = b_q;
    cnt_d   = cnt_q;
    out_d   = out_q;
    ovld_d  = ovld_q;
    if (ovld_q && m_axis_tready) begin
      ovld_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (m_q < WORD_BITS'(2)) begin
            acc_d   = '0;
            state_d = ST_DONE;
          end else begin
            p_d     = '0;
            b_d     = s_axis_tdata[WORD_BITS-1:0];
            cnt_d   = '0;
            esh_d   = e_q;
            acc_d   = WORD_BITS'(1);
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE, ST_MULT, ST_SQUARE: begin
        p_d   = step_res;
        b_d   = b_q << 1;
        cnt_d = cnt_q + CNT_BITS'(1);
        if (last) begin
          p_d   = '0;
          cnt_d = '0;
          if (state_q == ST_MULT) begin
            acc_d = step_res;
            if ((esh_q >> 1) == '0) begin
              state_d = ST_DONE;
            end else begin
              b_d     = sq_q;
              state_d = ST_SQUARE;
            end
          end else begin
            sq_d  = step_res;
            esh_d = nxt_e;
            if (nxt_e == '0) begin
              state_d = ST_DONE;
            end else if (nxt_e[0]) begin
              b_d     = acc_q;
              state_d = ST_MULT;
            end else begin
              b_d     = step_res;
              state_d = ST_SQUARE;
            end
          end
        end
      end
      ST_DONE: begin
        if (!ovld_q || m_axis_tready) begin
          out_d   = acc_q;
          ovld_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ovld_q  <= 1'b0;
      m_q     <= RST_MODULUS[WORD_BITS-1:0];
      e_q     <= RST_EXPONENT[WORD_BITS-1:0];
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MODULUS) begin
          m_q <= cfg_wdata_i;
        end else if (cfg_idx_i == REG_EXPONENT) begin
          e_q <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    esh_q <= esh_d;
    sq_q  <= sq_d;
    acc_q <= acc_d;
    p_q   <= p_d;
    b_q   <= b_d;
    cnt_q <= cnt_d;
    out_q <= out_d;
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = TDATA_BITS'(out_q);

`include "modular_exponentiation_macros.svh"

  `MEXP_ASSERT(a_acc_reduced, clk_i, rst_ni, mul_phase |-> (acc_q < m_q))
  `MEXP_ASSERT(a_sq_reduced, clk_i, rst_ni, mul_phase |-> (sq_q < m_q))
  `MEXP_ASSERT(a_done_holds, clk_i, rst_ni, (state_q == ST_DONE && ovld_q && !m_axis_tready) |=> (state_q == ST_DONE))
  `MEXP_ASSERT_NEVER(a_partial_range, clk_i, rst_ni, (step_phase && p_q >= m_q))

endmodule
